>>> design/assert_macros.svh
// Assertion macros shared by the sprite pixel decoder modules.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that holds at every edge.
`define SPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    `SPD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> design/spd_pkg.sv
// Package for the sprite pixel decoder: sizes, codes and shared types.
// Used by every module and interface of the block.
package spd_pkg;

    localparam int GRAPHICS_BYTES = 49152;
    localparam int PLANE_SIZE     = GRAPHICS_BYTES / 3;
    localparam int TOP_SIZE       = GRAPHICS_BYTES - 2 * PLANE_SIZE;
    localparam int PLANE_AW       = $clog2(PLANE_SIZE);
    localparam int TOP_AW         = $clog2(TOP_SIZE);
    localparam int OFFSET_W       = 14;
    localparam int BYTE_W         = 8;
    localparam int CLUT_DEPTH     = 256;
    localparam int CLUT_AW        = 8;
    localparam int COLOUR_W       = 5;
    localparam int POS_W          = 9;

    localparam int ATTR_CODE_HI   = 5;
    localparam int ATTR_NO_FLIP_X = 6;
    localparam int ATTR_NO_FLIP_Y = 7;

    localparam logic [8:0] COLOR_BASE = 9'h010;

    typedef enum logic [1:0] {
        MODE_GFX    = 2'd0,
        MODE_CLUT   = 2'd1,
        MODE_RENDER = 2'd2
    } mode_t;

    typedef struct packed {
        logic                valid;
        logic [2:0]          pen;
        logic [COLOUR_W-1:0] colour;
        logic [POS_W-1:0]    px;
        logic [POS_W-1:0]    py;
    } fetch_t;

    typedef struct packed {
        logic               we;
        logic [CLUT_AW-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } clut_wr_t;

endpackage

>>> design/spd_if.sv
// Channel interfaces of the sprite pixel decoder: command items and pixel items.
// Depends on spd_pkg for field widths.
interface spd_cmd_if import spd_pkg::*;;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  sprite_y;
    logic [7:0]  sprite_attr;
    logic [7:0]  sprite_code;
    logic [7:0]  sprite_x;
    logic [3:0]  col;
    logic [3:0]  row;

    modport source (
        output valid, mode, address, data, sprite_y, sprite_attr, sprite_code,
               sprite_x, col, row,
        input  ready
    );
    modport sink (
        input  valid, mode, address, data, sprite_y, sprite_attr, sprite_code,
               sprite_x, col, row,
        output ready
    );
endinterface

interface spd_pix_if import spd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pixel_x;
    logic [POS_W-1:0] pixel_y;
    logic [8:0]       color;
    logic [2:0]       pen;

    modport source (
        output valid, pixel_x, pixel_y, color, pen,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, color, pen,
        output ready
    );
endinterface

>>> design/spd_ram.sv
// Generic byte-wide synchronous RAM with one write port and NRD registered read ports.
// Depends on spd_pkg for the byte width.
module spd_ram import spd_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH),
    parameter int NRD   = 1
)
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [BYTE_W-1:0]          wdata,
    input  logic                       re,
    input  logic [NRD-1:0][AW-1:0]     raddr,
    output logic [NRD-1:0][BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            for (int i = 0; i < NRD; i++)
            begin
                rdata[i] <= mem[raddr[i]];
            end
        end
    end

endmodule

>>> design/spd_fetch.sv
// Command intake, graphics plane banks and pen assembly of the sprite pixel decoder.
// Depends on spd_pkg, spd_if, spd_ram and assert_macros.svh.
`include "assert_macros.svh"

module spd_fetch import spd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    spd_cmd_if.sink    cmd,
    input  logic       advance,
    output fetch_t     fetch,
    output clut_wr_t   clut_wr
);

    logic                accept;
    logic                render_acc;
    logic                gfx_we;
    logic                we0;
    logic                we1;
    logic                we2;
    logic [15:0]         addr1;
    logic [15:0]         addr2;
    logic [8:0]          code;
    logic [3:0]          ex;
    logic [3:0]          ey;
    logic [OFFSET_W-1:0] offset;
    logic [OFFSET_W-1:0] spill_off;
    logic                spill;
    logic                ok1;
    logic                ok2;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [2:0]          bit_reg;
    logic                spill_reg;
    logic                ok1_reg;
    logic                ok2_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic [POS_W-1:0]    px_reg;
    logic [POS_W-1:0]    py_reg;

    logic [0:0][BYTE_W-1:0] q0;
    logic [1:0][BYTE_W-1:0] q1;
    logic [1:0][BYTE_W-1:0] q2;
    logic [BYTE_W-1:0]      byte0;
    logic [BYTE_W-1:0]      byte1;
    logic [BYTE_W-1:0]      byte2;

    assign cmd.ready  = advance || !s1_valid_reg;
    assign accept     = cmd.valid && cmd.ready;
    assign render_acc = accept && (cmd.mode == MODE_RENDER);
    assign gfx_we     = accept && (cmd.mode == MODE_GFX);

    assign clut_wr.we   = accept && (cmd.mode == MODE_CLUT) && (cmd.address[15:8] == 8'd0);
    assign clut_wr.addr = cmd.address[7:0];
    assign clut_wr.data = cmd.data;

    assign we0   = gfx_we && (cmd.address < PLANE_SIZE);
    assign we1   = gfx_we && (cmd.address >= PLANE_SIZE) && (cmd.address < 2 * PLANE_SIZE);
    assign we2   = gfx_we && (cmd.address >= 2 * PLANE_SIZE)
                   && (cmd.address < GRAPHICS_BYTES);
    assign addr1 = cmd.address - 16'(PLANE_SIZE);
    assign addr2 = cmd.address - 16'(2 * PLANE_SIZE);

    // The tile code, column half and row pack directly into the plane offset.
    always_comb
    begin
        code      = {cmd.sprite_attr[ATTR_CODE_HI], cmd.sprite_code};
        ex        = cmd.sprite_attr[ATTR_NO_FLIP_X] ? cmd.col : ~cmd.col;
        ey        = cmd.sprite_attr[ATTR_NO_FLIP_Y] ? cmd.row : ~cmd.row;
        offset    = {code, ~ex[3], ey};
        spill     = (offset >= PLANE_SIZE);
        spill_off = offset - OFFSET_W'(PLANE_SIZE);
        ok1       = !spill || (spill_off < TOP_SIZE);
        ok2       = (offset < TOP_SIZE);
    end

    spd_ram #(.DEPTH(PLANE_SIZE), .AW(PLANE_AW), .NRD(1)) u_bank0 (
        .clk   (clk),
        .we    (we0),
        .waddr (PLANE_AW'(cmd.address)),
        .wdata (cmd.data),
        .re    (render_acc),
        .raddr (PLANE_AW'(offset)),
        .rdata (q0)
    );

    spd_ram #(.DEPTH(PLANE_SIZE), .AW(PLANE_AW), .NRD(2)) u_bank1 (
        .clk   (clk),
        .we    (we1),
        .waddr (PLANE_AW'(addr1)),
        .wdata (cmd.data),
        .re    (render_acc),
        .raddr ({PLANE_AW'(spill_off), PLANE_AW'(offset)}),
        .rdata (q1)
    );

    spd_ram #(.DEPTH(TOP_SIZE), .AW(TOP_AW), .NRD(2)) u_bank2 (
        .clk   (clk),
        .we    (we2),
        .waddr (TOP_AW'(addr2)),
        .wdata (cmd.data),
        .re    (render_acc),
        .raddr ({TOP_AW'(spill_off), TOP_AW'(offset)}),
        .rdata (q2)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = render_acc;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (render_acc)
        begin
            bit_reg    <= ex[2:0];
            spill_reg  <= spill;
            ok1_reg    <= ok1;
            ok2_reg    <= ok2;
            colour_reg <= cmd.sprite_attr[COLOUR_W-1:0];
            px_reg     <= {1'b0, cmd.sprite_x} + {5'd0, cmd.col};
            py_reg     <= {1'b0, cmd.sprite_y} + {5'd0, cmd.row};
        end
    end

    // A plane offset past the end of its bank continues in the next bank.
    always_comb
    begin
        byte0 = spill_reg ? q1[1] : q0[0];
        byte1 = spill_reg ? (ok1_reg ? q2[1] : '0) : q1[0];
        byte2 = ok2_reg ? q2[0] : '0;
    end

    assign fetch.valid  = s1_valid_reg;
    assign fetch.pen    = {byte2[bit_reg], byte1[bit_reg], byte0[bit_reg]};
    assign fetch.colour = colour_reg;
    assign fetch.px     = px_reg;
    assign fetch.py     = py_reg;

    `SPD_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !advance,
                     s1_valid_reg && $stable(px_reg) && $stable(bit_reg),
                     "stalled fetch stage changed")
    `SPD_ASSERT(a_in_range, s1_valid_reg && !spill_reg |-> ok1_reg,
                "plane one read out of range without spill")

endmodule

>>> design/spd_color.sv
// Colour table and output register of the sprite pixel decoder.
// Depends on spd_pkg, spd_ram and assert_macros.svh.
`include "assert_macros.svh"

module spd_color import spd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  fetch_t           fetch,
    input  clut_wr_t         clut_wr,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [POS_W-1:0] out_x,
    output logic [POS_W-1:0] out_y,
    output logic [8:0]       out_color,
    output logic [2:0]       out_pen
);

    logic                   s2_valid_reg;
    logic                   s2_valid_next;
    logic [POS_W-1:0]       px_reg;
    logic [POS_W-1:0]       py_reg;
    logic [2:0]             pen_reg;
    logic                   rd_en;
    logic [0:0][BYTE_W-1:0] clut_q;

    assign advance = !s2_valid_reg || out_ready;
    assign rd_en   = advance && fetch.valid;

    spd_ram #(.DEPTH(CLUT_DEPTH), .AW(CLUT_AW), .NRD(1)) u_clut (
        .clk   (clk),
        .we    (clut_wr.we),
        .waddr (clut_wr.addr),
        .wdata (clut_wr.data),
        .re    (rd_en),
        .raddr ({fetch.colour, fetch.pen}),
        .rdata (clut_q)
    );

    // A transparent pen drops the item here.
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (advance)
        begin
            s2_valid_next = fetch.valid && (fetch.pen != 3'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            px_reg  <= fetch.px;
            py_reg  <= fetch.py;
            pen_reg <= fetch.pen;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_x     = px_reg;
    assign out_y     = py_reg;
    assign out_color = COLOR_BASE + {1'b0, clut_q[0]};
    assign out_pen   = pen_reg;

    `SPD_ASSERT(a_pen_nonzero, s2_valid_reg |-> (pen_reg != 3'd0),
                "transparent pen reached the output")
    `SPD_ASSERT_NEXT(a_out_holds, s2_valid_reg && !out_ready,
                     s2_valid_reg && $stable(pen_reg) && $stable(px_reg),
                     "stalled output register changed")

endmodule

>>> design/sprite_pixel_decoder.sv
// Top level of the sprite pixel decoder: command intake, plane fetch, colour lookup.
// Depends on spd_pkg, spd_if, spd_fetch and spd_color.
//
//   Port   Modport  Items
//   cmd    sink     graphics writes, colour table writes, render requests
//   pix    source   visible sprite pixels with screen position and color
//
// One command item is taken per clock unless the pix channel stalls; a render result
// passes through the registered read of the plane banks and then the colour table.
// Writes take effect at acceptance, so a render right after a write sees the new byte.
// Reset clears only the stage valid bits; the memories hold nothing until written.
// A stalled pix channel holds the output register and then the fetch stage.
module sprite_pixel_decoder import spd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    spd_cmd_if.sink    cmd,
    spd_pix_if.source  pix
);

    fetch_t   fetch;
    clut_wr_t clut_wr;
    logic     advance;

    spd_fetch u_fetch (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .advance (advance),
        .fetch   (fetch),
        .clut_wr (clut_wr)
    );

    spd_color u_color (
        .clk       (clk),
        .rst_n     (rst_n),
        .fetch     (fetch),
        .clut_wr   (clut_wr),
        .advance   (advance),
        .out_valid (pix.valid),
        .out_ready (pix.ready),
        .out_x     (pix.pixel_x),
        .out_y     (pix.pixel_y),
        .out_color (pix.color),
        .out_pen   (pix.pen)
    );

endmodule
